// File: sv/chsq_pkg.sv
// ----------------------------------------------------------------------------
// chsq_pkg
// Shared types and constants for the convex hull support query block.
// ----------------------------------------------------------------------------
package chsq_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_FRAC_BITS    = 16;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch input word
        logic clear;      // zero count and radius
        logic store;      // write vertex, start sqrt
        logic sqrt_step;  // one square, fold or sqrt step
        logic radius_upd; // fold sqrt result into radius
        logic walk_start; // reset walk index
        logic walk_step;  // read next vertex
        logic load_res;   // load output register
    } chsq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic sqrt_done;
        logic walk_done;
    } chsq_sts_t;

endpackage

// File: sv/chsq_ctrl.sv
// ----------------------------------------------------------------------------
// chsq_ctrl
// Sequencer: decodes a command word and steps the datapath through it.
// ----------------------------------------------------------------------------
module chsq_ctrl
    import chsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_command,
    output logic       in_stall,
    input  logic       out_busy,
    output chsq_cmd_t  cmd,
    input  chsq_sts_t  sts
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_SQRT  = 6'b000100,
        S_WALK  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [2:0] drain_reg, drain_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        drain_next = drain_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = in_command;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                if (op_reg == CMD_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_DONE;
                end
                else if (op_reg == CMD_ADD && !sts.full)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_SQRT;
                end
                else if (op_reg == CMD_QUERY && !sts.empty)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                    state_next = S_DONE;
            end
            S_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.radius_upd = 1'b1;
                    state_next     = S_DONE;
                end
                else
                    cmd.sqrt_step = 1'b1;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    drain_next = 3'd4;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.walk_step = 1'b1;
                drain_next    = drain_reg - 3'd1;
                if (drain_reg == 3'd1)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_CLEAR;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            drain_reg <= drain_next;
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("stall low while busy");
    a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |=> (state_reg == S_IDLE))
        else $error("result load did not return to idle");
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.store, cmd.walk_start, cmd.load_res}))
        else $error("conflicting commands");

endmodule

// File: sv/chsq_dp.sv
// ----------------------------------------------------------------------------
// chsq_dp
// Vertex memory, radius square root unit and dot product walk pipeline.
// ----------------------------------------------------------------------------
module chsq_dp
    import chsq_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  chsq_cmd_t          cmd,
    output chsq_sts_t          sts,
    input  logic [1:0]         in_command,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    output logic [191:0]       res_vert,
    output logic [31:0]        res_radius,
    output logic [6:0]         res_count,
    output logic [1:0]         res_status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // the squared length is taken in the raw Q scale, so the root keeps FRAC_BITS
    localparam int SQ_W  = 66;
    localparam int SQ_IT = SQ_W / 2;

    logic [1:0]         op_reg;
    logic               add_full_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [CW-1:0]      count_reg;
    logic [31:0]        radius_reg;

    logic [95:0] mem [MAX_VERTICES];

    // ---------------- capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= in_command;
            add_full_reg <= (in_command == CMD_ADD) && sts.full;
            vx_reg       <= in_x;
            vy_reg       <= in_y;
            vz_reg       <= in_z;
        end
    end

    assign sts.full  = (count_reg >= CW'(MAX_VERTICES));
    assign sts.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            mem[count_reg[AW-1:0]] <= {vx_reg, vy_reg, vz_reg};
    end

    // ---------------- square sum, one multiply per cycle, then restoring sqrt
    logic [1:0]           sq_ph_reg;
    logic signed [63:0]   prod_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [SQ_W-1:0]      rem_reg;
    logic [SQ_IT-1:0]     root_reg;
    logic [5:0]           it_reg;
    logic                 sq_ready;
    logic signed [31:0]   sq_op;
    logic [SQ_W-1:0]      trial;
    logic [SQ_W-1:0]      rem_sh;

    always_comb
    begin
        unique case (sq_ph_reg)
            2'd0:    sq_op = vx_reg;
            2'd1:    sq_op = vy_reg;
            default: sq_op = vz_reg;
        endcase
    end

    assign sq_ready = (sq_ph_reg == 2'd3) && (it_reg == 6'(SQ_IT));
    assign sts.sqrt_done = sq_ready;
    assign rem_sh = {rem_reg[SQ_W-3:0], sq_reg[SQ_W-1 -: 2]};
    assign trial  = {{(SQ_W-SQ_IT-2){1'b0}}, root_reg, 2'b01};

    // phases 0..2 multiply, phase 3 folds the last product then iterates the root
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            sq_ph_reg <= 2'd0;
            sq_reg    <= '0;
            prod_reg  <= '0;
            it_reg    <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_ph_reg != 2'd3)
            begin
                prod_reg <= sq_op * sq_op;
                sq_reg   <= sq_reg + SQ_W'($unsigned(prod_reg));
                if (sq_ph_reg == 2'd2)
                begin
                    sq_ph_reg <= 2'd3;
                    it_reg    <= 6'd63;
                end
                else
                    sq_ph_reg <= sq_ph_reg + 2'd1;
            end
            else if (it_reg == 6'd63)
            begin
                // fold in last product, begin iterations
                sq_reg <= sq_reg + SQ_W'($unsigned(prod_reg));
                it_reg <= '0;
            end
            else
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[SQ_IT-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[SQ_IT-2:0], 1'b0};
                end
                sq_reg <= {sq_reg[SQ_W-3:0], 2'b00};
                it_reg <= it_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            radius_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg  <= '0;
            radius_reg <= '0;
        end
        else
        begin
            if (cmd.store)
                count_reg <= count_reg + CW'(1);
            if (cmd.radius_upd && (root_reg[31:0] > radius_reg))
                radius_reg <= root_reg[31:0];
        end
    end

    // ---------------- query walk: read -> multiply -> sum -> compare
    logic [CW-1:0]       rd_idx_reg;
    logic                v0_reg, v1_reg, v2_reg;
    logic [95:0]         rd_reg, p1_vert_reg, p2_vert_reg;
    logic signed [63:0]  px_reg, py_reg, pz_reg;
    logic signed [65:0]  dot_reg;
    logic signed [65:0]  dmin_reg, dmax_reg;
    logic [95:0]         vmin_reg, vmax_reg;
    logic                first_reg;

    assign sts.walk_done = (rd_idx_reg == count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.walk_start)
        begin
            rd_idx_reg <= '0;
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            first_reg  <= 1'b1;
        end
        else if (cmd.walk_step)
        begin
            v0_reg <= (rd_idx_reg != count_reg);
            if (rd_idx_reg != count_reg)
            begin
                rd_reg     <= mem[rd_idx_reg[AW-1:0]];
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            px_reg      <= $signed(rd_reg[95:64]) * vx_reg;
            py_reg      <= $signed(rd_reg[63:32]) * vy_reg;
            pz_reg      <= $signed(rd_reg[31:0])  * vz_reg;
            p1_vert_reg <= rd_reg;
            v1_reg      <= v0_reg;
            dot_reg     <= 66'(px_reg) + 66'(py_reg) + 66'(pz_reg);
            p2_vert_reg <= p1_vert_reg;
            v2_reg      <= v1_reg;
            if (v2_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || dot_reg > dmax_reg)
                begin
                    dmax_reg <= dot_reg;
                    vmax_reg <= p2_vert_reg;
                end
                if (first_reg || dot_reg < dmin_reg)
                begin
                    dmin_reg <= dot_reg;
                    vmin_reg <= p2_vert_reg;
                end
            end
        end
    end

    // ---------------- result word
    logic ok_query;
    assign ok_query = (op_reg == CMD_QUERY) && !sts.empty;

    always_comb
    begin
        res_vert   = ok_query ? {vmin_reg, vmax_reg} : '0;
        res_radius = radius_reg;
        res_count  = 7'(count_reg);
        res_status = ST_OK;
        if (op_reg == CMD_QUERY && sts.empty)
            res_status = ST_EMPTY;
        else if (add_full_reg)
            res_status = ST_FULL;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count overflow");
    a_no_store_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !sts.full)
        else $error("store into full table");
    a_radius_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.clear) |-> radius_reg >= $past(radius_reg))
        else $error("radius decreased without clear");

endmodule

// File: sv/convex_hull_support_query.sv
// ----------------------------------------------------------------------------
// convex_hull_support_query
// Hull vertex table with bounding radius and min/max support queries.
// ----------------------------------------------------------------------------
// Clear, refused add, empty query and unused command go from decode straight
// to the result load; add runs three squares, a fold and a 33-step root;
// query runs the dot product walk over the stored vertices, one vertex per cycle.
// Throughput: one word at a time, the next accepted after the result loads.
// Reset clears count, radius and control; the vertex memory is not cleared.
module convex_hull_support_query
    import chsq_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] min_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] min_z,
    output logic signed [31:0] max_x,
    output logic signed [31:0] max_y,
    output logic signed [31:0] max_z,
    output logic [31:0]        bound_radius,
    output logic [6:0]         stored_count,
    output logic [1:0]         status
);

    chsq_cmd_t    cmd;
    chsq_sts_t    sts;
    logic [191:0] res_vert;
    logic [31:0]  res_radius;
    logic [6:0]   res_count;
    logic [1:0]   res_status;
    logic         out_valid_reg;
    logic [191:0] vert_reg;
    logic [31:0]  radius_o_reg;
    logic [6:0]   count_o_reg;
    logic [1:0]   status_reg;

    chsq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (command),
        .in_stall   (in_stall),
        .out_busy   (out_valid_reg && out_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    chsq_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_command (command),
        .in_x       (vec_x),
        .in_y       (vec_y),
        .in_z       (vec_z),
        .res_vert   (res_vert),
        .res_radius (res_radius),
        .res_count  (res_count),
        .res_status (res_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_res)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            vert_reg     <= res_vert;
            radius_o_reg <= res_radius;
            count_o_reg  <= res_count;
            status_reg   <= res_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_x        = vert_reg[191:160];
    assign min_y        = vert_reg[159:128];
    assign min_z        = vert_reg[127:96];
    assign max_x        = vert_reg[95:64];
    assign max_y        = vert_reg[63:32];
    assign max_z        = vert_reg[31:0];
    assign bound_radius = radius_o_reg;
    assign stored_count = count_o_reg;
    assign status       = status_reg;

endmodule
